// ----- rtl/core/ghmu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghmu_pkg: shared types and helpers for the gap material point
// Modes, sequencer states, shared multiply/divide unit command and response,
// and the Q16.16 saturation helpers.
// ----------------------------------------------------------------------------
package ghmu_pkg;

	localparam int unsigned FRAC      = 16;
	localparam int unsigned ACC_W     = 82;   // widest product: 49 x 33 bits
	localparam int unsigned OPND_W    = 49;   // multiplicand or divisor
	localparam int unsigned SH_W      = 48;   // multiplier (top bits) or dividend
	localparam int unsigned MPLIER_W  = 33;
	localparam int unsigned MUL_STEPS = 33;
	localparam int unsigned DIV_STEPS = 48;
	localparam int unsigned CNT_W     = 6;

	localparam logic [31:0] STIFF_RST = 32'h0001_0000;
	localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX   = 32'h8000_0000;

	typedef enum logic [1:0] {
		MODE_TRIAL      = 2'd0,
		MODE_COMMIT     = 2'd1,
		MODE_REV_COMMIT = 2'd2,
		MODE_REV_START  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_LD_MUL,
		S_SQ,
		S_PC_MUL,
		S_TAN_MUL,
		S_DIV,
		S_FIN
	} state_t;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic {
		REG_STIFFNESS = 1'b0,
		REG_GAP       = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] stiffness;
		logic [31:0] gap;
	} cfg_t;

	typedef struct packed {
		logic              start;
		op_t               op;
		logic [OPND_W-1:0] a;
		logic [SH_W-1:0]   b;
	} mdu_cmd_t;

	typedef struct packed {
		logic             done;
		logic [ACC_W-1:0] res;
	} mdu_rsp_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] stress;
		logic [31:0] tangent;
		logic [31:0] strain;
		logic        saturated;
	} result_t;

	typedef struct packed {
		logic [31:0] val;
		logic        clip;
	} sat_t;

	// magnitude plus sign to signed 32 bits, clipped at the signed limits
	function automatic sat_t sat_mag(input logic [ACC_W-FRAC-1:0] mag, input logic neg);
		sat_t                  r;
		logic [ACC_W-FRAC-1:0] lim;
		logic [31:0]           m;
		lim = neg ? (ACC_W-FRAC)'(NEG_MAX) : (ACC_W-FRAC)'(POS_MAX);
		if (mag > lim) begin
			m      = lim[31:0];
			r.clip = 1'b1;
		end else begin
			m      = mag[31:0];
			r.clip = 1'b0;
		end
		r.val = neg ? 32'(-m) : m;
		return r;
	endfunction

	function automatic sat_t sat33(input logic signed [32:0] v);
		sat_t r;
		if (v[32] != v[31]) begin
			r.clip = 1'b1;
			r.val  = v[32] ? NEG_MAX : POS_MAX;
		end else begin
			r.clip = 1'b0;
			r.val  = v[31:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/ghmu_intf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghmu channel interfaces
// Valid/ready channels for input words, result words and register writes.
// ----------------------------------------------------------------------------
interface ghmu_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic signed [31:0] strain;
	modport source (output valid, mode, strain, input ready);
	modport sink   (input valid, mode, strain, output ready);
endinterface

interface ghmu_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] stress;
	logic signed [31:0] tangent;
	logic signed [31:0] current_strain;
	logic               saturated;
	modport source (output valid, stress, tangent, current_strain, saturated, input ready);
	modport sink   (input valid, stress, tangent, current_strain, saturated, output ready);
endinterface

interface ghmu_cfg_if;
	logic        valid;
	logic        ready;
	logic        reg_idx;
	logic [31:0] wdata;
	modport source (output valid, reg_idx, wdata, input ready);
	modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

// ----- rtl/core/gap_hysteretic_material_update.sv -----
`timescale 1ns / 1ps
// Accept to result valid: a loading trial runs one multiply, an unloading trial
// three (square, product, tangent), an origin commit one divide, a coefficient
// commit a square and a divide; reverts and trials in the gap use no unit. One word
// at a time; the next is taken once the sequencer is idle, and all arithmetic runs
// on the shared 82-bit unit.
// Reset clears the material state and gap to zero, stiffness to 1.0; the result data is not reset.
// ----------------------------------------------------------------------------
// gap_hysteretic_material_update: uniaxial gap material point, Q16.16
// Configuration registers, material core with shared multiply/divide unit,
// and the result output register.
// ----------------------------------------------------------------------------
module gap_hysteretic_material_update (
	input  logic      clk,
	input  logic      arst_n,
	ghmu_cfg_if.sink  cfg,
	ghmu_in_if.sink   item_in,
	ghmu_out_if.source result_out
);
	import ghmu_pkg::*;

	cfg_t     cfg_q;
	mdu_cmd_t mdu_cmd;
	mdu_rsp_t mdu_rsp;
	result_t  result;
	logic     out_free;
	logic     out_valid_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stiffness <= STIFF_RST;
			cfg_q.gap       <= '0;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.reg_idx))
				REG_STIFFNESS: cfg_q.stiffness <= cfg.wdata;
				REG_GAP:       cfg_q.gap       <= cfg.wdata;
			endcase
		end
	end

	ghmu_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (item_in.valid),
		.in_ready  (item_in.ready),
		.in_mode   (item_in.mode),
		.in_strain (item_in.strain),
		.mdu_cmd   (mdu_cmd),
		.mdu_rsp   (mdu_rsp),
		.out_free  (out_free),
		.result    (result)
	);

	ghmu_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mdu_cmd),
		.rsp    (mdu_rsp)
	);

	assign out_free = !out_valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.valid && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result word until taken
	always_ff @(posedge clk) begin
		if (result.valid && out_free) begin
			result_out.stress         <= result.stress;
			result_out.tangent        <= result.tangent;
			result_out.current_strain <= result.strain;
			result_out.saturated      <= result.saturated;
		end
	end

	assign result_out.valid = out_valid_q;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && out_free |=> result_out.valid && !result.valid)
		else $error("finished word not moved to the output register");

endmodule

// ----- rtl/core/ghmu_mdu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghmu_mdu: shared iterative multiply/divide unit
// One 83-bit adder: shift-add multiply (one multiplier bit a cycle) or
// restoring divide (one quotient bit a cycle). Done pulses one cycle.
// ----------------------------------------------------------------------------
module ghmu_mdu (
	input  logic              clk,
	input  logic              arst_n,
	input  ghmu_pkg::mdu_cmd_t cmd,
	output ghmu_pkg::mdu_rsp_t rsp
);
	import ghmu_pkg::*;

	logic              busy_q;
	logic              done_q;
	op_t               op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ACC_W-1:0]  acc_q;
	logic [SH_W-1:0]   sh_q;
	logic [OPND_W-1:0] opnd_q;

	logic [ACC_W:0]    add_x;
	logic [ACC_W:0]    add_y;
	logic              add_cin;
	logic [ACC_W:0]    sum;
	logic [OPND_W-1:0] part;
	logic              qbit;
	logic [OPND_W-1:0] rem_n;

	always_comb begin
		// partial remainder with the next dividend bit shifted in
		part = {acc_q[OPND_W-2:0], sh_q[SH_W-1]};
		if (op_q == OP_MUL) begin
			add_x   = {1'b0, acc_q[ACC_W-2:0], 1'b0};
			add_y   = sh_q[SH_W-1] ? (ACC_W+1)'(opnd_q) : '0;
			add_cin = 1'b0;
		end else begin
			add_x   = (ACC_W+1)'(part);
			add_y   = ~((ACC_W+1)'(opnd_q));
			add_cin = 1'b1;
		end
		sum   = add_x + add_y + (ACC_W+1)'(add_cin);
		qbit  = ~sum[ACC_W];
		rem_n = qbit ? sum[OPND_W-1:0] : part;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				op_q   <= cmd.op;
				cnt_q  <= (cmd.op == OP_MUL) ? CNT_W'(MUL_STEPS) : CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q  <= '0;
			opnd_q <= cmd.a;
			sh_q   <= (cmd.op == OP_MUL) ? {cmd.b[MPLIER_W-1:0], (SH_W-MPLIER_W)'(0)} : cmd.b;
		end else if (busy_q) begin
			if (op_q == OP_MUL) begin
				acc_q <= sum[ACC_W-1:0];
				sh_q  <= {sh_q[SH_W-2:0], 1'b0};
			end else begin
				acc_q <= ACC_W'(rem_n);
				sh_q  <= {sh_q[SH_W-2:0], qbit};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == OP_MUL) ? acc_q : ACC_W'(sh_q);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy_q)
		else $error("mdu started while busy");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !cmd.start && cnt_q == CNT_W'(1) |=> rsp.done && !busy_q)
		else $error("mdu did not finish after last step");

endmodule

// ----- rtl/core/ghmu_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghmu_core: material state and sequencer
// Holds the committed and trial state, decides the branch of each word and
// drives the shared multiply/divide unit through squares, products, quotients.
// ----------------------------------------------------------------------------
module ghmu_core (
	input  logic                clk,
	input  logic                arst_n,
	input  ghmu_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_mode,
	input  logic signed [31:0]  in_strain,
	output ghmu_pkg::mdu_cmd_t  mdu_cmd,
	input  ghmu_pkg::mdu_rsp_t  mdu_rsp,
	input  logic                out_free,
	output ghmu_pkg::result_t   result
);
	import ghmu_pkg::*;

	state_t             state_q, state_d;
	mode_t              mode_q;
	logic               flag_q;
	logic signed [31:0] ts_q, cs_q, stress_q, tangent_q, origin_q, pc_q;

	logic signed [31:0] gap;
	logic signed [32:0] d, dorg;
	logic [32:0]        d_mag, dorg_mag;
	logic [31:0]        pc_mag, stress_mag;
	logic [32:0]        pc2_mag;
	logic [SH_W-1:0]    dividend;
	logic [SH_W-1:0]    sq;
	logic               gap_neg, gap_pos;
	logic               ts_gt_gap, ts_lt_gap, ts_gt_cs, ts_lt_cs;
	logic               t_past, t_load, t_unload, c_past, move_org;
	logic               mul_neg;
	logic [31:0]        div_ext;
	sat_t               mul_sat, div_sat, org_div, org_ext;

	always_comb begin
		gap        = $signed(cfg.gap);
		d          = $signed({ts_q[31], ts_q}) - $signed({gap[31], gap});
		dorg       = $signed({ts_q[31], ts_q}) - $signed({origin_q[31], origin_q});
		d_mag      = d[32] ? 33'(-d) : 33'(d);
		dorg_mag   = dorg[32] ? 33'(-dorg) : 33'(dorg);
		pc_mag     = pc_q[31] ? 32'(-pc_q) : 32'(pc_q);
		pc2_mag    = {pc_mag, 1'b0};
		stress_mag = stress_q[31] ? 32'(-stress_q) : 32'(stress_q);
		dividend   = {stress_mag, FRAC'(0)};
		sq         = mdu_rsp.res[SH_W+FRAC-1:FRAC];

		gap_neg   = gap[31];
		gap_pos   = !gap_neg && (gap != 32'sd0);
		ts_gt_gap = ts_q > gap;
		ts_lt_gap = ts_q < gap;
		ts_gt_cs  = ts_q > cs_q;
		ts_lt_cs  = ts_q < cs_q;
		t_past    = gap_neg ? ts_lt_gap : ts_gt_gap;
		t_load    = gap_neg ? ts_lt_cs : ts_gt_cs;
		t_unload  = gap_neg ? ts_gt_cs : ts_lt_cs;
		c_past    = (gap_pos && ts_gt_gap) || (gap_neg && ts_lt_gap);
		// tension and compression sides both move the origin on unloading
		move_org  = gap_pos ? ts_lt_cs : ts_gt_cs;

		unique case (state_q)
			S_LD_MUL: mul_neg = dorg[32];
			S_PC_MUL: mul_neg = pc_q[31];
			default:  mul_neg = pc_q[31] ^ d[32];
		endcase
		mul_sat = sat_mag(mdu_rsp.res[ACC_W-1:FRAC], mul_neg);
		div_sat = sat_mag((ACC_W-FRAC)'(mdu_rsp.res[SH_W-1:0]), stress_q[31]);
		div_ext = stress_q[31] ? NEG_MAX : POS_MAX;
		org_div = sat33($signed({ts_q[31], ts_q}) - $signed({div_sat.val[31], div_sat.val}));
		org_ext = sat33($signed({ts_q[31], ts_q}) - $signed({div_ext[31], div_ext}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		mdu_cmd.start = 1'b0;
		mdu_cmd.op    = OP_MUL;
		mdu_cmd.a     = '0;
		mdu_cmd.b     = '0;
		in_ready      = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				state_d = S_FIN;
				unique case (mode_q)
					MODE_TRIAL: begin
						if (t_past && t_load) begin
							mdu_cmd.start = 1'b1;
							mdu_cmd.a     = OPND_W'(cfg.stiffness);
							mdu_cmd.b     = SH_W'(dorg_mag);
							state_d       = S_LD_MUL;
						end else if (t_past && t_unload) begin
							mdu_cmd.start = 1'b1;
							mdu_cmd.a     = OPND_W'(d_mag);
							mdu_cmd.b     = SH_W'(d_mag);
							state_d       = S_SQ;
						end
					end
					MODE_COMMIT: begin
						if (c_past && move_org) begin
							if (stress_q != 32'sd0 && cfg.stiffness != 32'd0) begin
								mdu_cmd.start = 1'b1;
								mdu_cmd.op    = OP_DIV;
								mdu_cmd.a     = OPND_W'(cfg.stiffness);
								mdu_cmd.b     = dividend;
								state_d       = S_DIV;
							end
						end else if (c_past) begin
							mdu_cmd.start = 1'b1;
							mdu_cmd.a     = OPND_W'(d_mag);
							mdu_cmd.b     = SH_W'(d_mag);
							state_d       = S_SQ;
						end
					end
					MODE_REV_COMMIT, MODE_REV_START: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_LD_MUL, S_TAN_MUL, S_DIV: begin
				if (mdu_rsp.done) state_d = S_FIN;
			end
			S_SQ: begin
				if (mdu_rsp.done) begin
					if (mode_q == MODE_TRIAL) begin
						mdu_cmd.start = 1'b1;
						mdu_cmd.a     = OPND_W'(sq);
						mdu_cmd.b     = SH_W'(pc_mag);
						state_d       = S_PC_MUL;
					end else if (stress_q != 32'sd0 && sq != '0) begin
						mdu_cmd.start = 1'b1;
						mdu_cmd.op    = OP_DIV;
						mdu_cmd.a     = OPND_W'(sq);
						mdu_cmd.b     = dividend;
						state_d       = S_DIV;
					end else begin
						state_d = S_FIN;
					end
				end
			end
			S_PC_MUL: begin
				if (mdu_rsp.done) begin
					mdu_cmd.start = 1'b1;
					mdu_cmd.a     = OPND_W'(pc2_mag);
					mdu_cmd.b     = SH_W'(d_mag);
					state_d       = S_TAN_MUL;
				end
			end
			S_FIN: begin
				if (out_free) state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TRIAL;
			flag_q    <= 1'b0;
			ts_q      <= '0;
			cs_q      <= '0;
			stress_q  <= '0;
			tangent_q <= '0;
			origin_q  <= '0;
			pc_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode_t'(in_mode);
						flag_q <= 1'b0;
						if (mode_t'(in_mode) == MODE_TRIAL) ts_q <= in_strain;
					end
				end
				S_DISPATCH: begin
					unique case (mode_q)
						MODE_TRIAL: begin
							if (t_past && t_load) begin
								tangent_q <= cfg.stiffness[31] ? POS_MAX : cfg.stiffness;
								flag_q    <= cfg.stiffness[31];
							end else if (!(t_past && t_unload)) begin
								stress_q  <= '0;
								tangent_q <= '0;
							end
						end
						MODE_COMMIT: begin
							if (c_past && move_org) begin
								if (stress_q == 32'sd0) begin
									origin_q <= ts_q;
								end else if (cfg.stiffness == 32'd0) begin
									origin_q <= org_ext.val;
									flag_q   <= 1'b1;
								end
							end
						end
						MODE_REV_COMMIT: ts_q <= cs_q;
						MODE_REV_START: begin
							cs_q     <= '0;
							ts_q     <= '0;
							origin_q <= gap;
						end
					endcase
				end
				S_LD_MUL, S_PC_MUL: begin
					if (mdu_rsp.done) begin
						stress_q <= mul_sat.val;
						flag_q   <= flag_q | mul_sat.clip;
					end
				end
				S_TAN_MUL: begin
					if (mdu_rsp.done) begin
						tangent_q <= mul_sat.val;
						flag_q    <= flag_q | mul_sat.clip;
					end
				end
				S_SQ: begin
					// commit with a zero numerator or a square that truncates to zero
					if (mdu_rsp.done && mode_q == MODE_COMMIT) begin
						if (stress_q == 32'sd0) begin
							pc_q <= '0;
						end else if (sq == '0) begin
							pc_q   <= div_ext;
							flag_q <= 1'b1;
						end
					end
				end
				S_DIV: begin
					if (mdu_rsp.done) begin
						if (c_past && move_org) begin
							origin_q <= org_div.val;
							flag_q   <= flag_q | div_sat.clip | org_div.clip;
						end else begin
							pc_q   <= div_sat.val;
							flag_q <= flag_q | div_sat.clip;
						end
					end
				end
				S_FIN: begin
					// committed strain moves last: the branch tests above read the old one
					if (out_free && mode_q == MODE_COMMIT) cs_q <= ts_q;
				end
			endcase
		end
	end

	assign result.valid     = (state_q == S_FIN);
	assign result.stress    = stress_q;
	assign result.tangent   = tangent_q;
	assign result.strain    = ts_q;
	assign result.saturated = flag_q;

	a_accept_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE && in_valid |=> state_q == S_DISPATCH)
		else $error("accepted word not dispatched");
	a_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_rsp.done |-> (state_q == S_LD_MUL || state_q == S_SQ || state_q == S_PC_MUL ||
			state_q == S_TAN_MUL || state_q == S_DIV))
		else $error("mdu result arrived outside a run state");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && !out_free |=> state_q == S_FIN && $stable(result))
		else $error("finished word changed before output register was free");

endmodule

// ----- bench/gap_hysteretic_material_update_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gap_hysteretic_material_update_tb: self-checking bench for the gap material
// Walks a short table of trial, commit and revert words (some with typed-in
// results), then random phases under several stiffness and gap settings.
// Each result word is compared against its typed-in result or a local Q16.16
// model of the material point; both channels idle and stall at random.
// ----------------------------------------------------------------------------
module gap_hysteretic_material_update_tb;
	import ghmu_pkg::*;

	localparam int HALF_PERIOD    = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int PHASES         = 8;
	localparam int PHASE_WORDS    = 104;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int TAIL_CYCLES    = 150;
	localparam int LONG_HOLD_AT   = 250;
	localparam int LONG_HOLD      = 600;
	localparam int MAX_REPORTS    = 10;
	localparam int SRC_SIDE       = 0;
	localparam int SNK_SIDE       = 1;

	typedef struct packed {
		logic [31:0] stress;
		logic [31:0] tangent;
		logic [31:0] strain;
		logic        sat;
	} point_t;

	typedef struct packed {
		logic [31:0] v;
		logic        clip;
	} q_t;

	typedef enum logic {
		ROW_WORD,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		mode_t       mode;
		reg_idx_t    widx;
		logic [31:0] value;
		logic        typed;
		point_t      want;
	} row_t;

	logic clk;
	logic arst_n;

	ghmu_cfg_if cfg_if ();
	ghmu_in_if  item_if ();
	ghmu_out_if res_if ();

	gap_hysteretic_material_update DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_if),
		.item_in    (item_if),
		.result_out (res_if)
	);

	// material model state
	logic [31:0]        mat_stiff;
	logic signed [31:0] mat_gap;
	logic signed [31:0] mat_committed;
	logic signed [31:0] mat_strain;
	logic signed [31:0] mat_stress;
	logic signed [31:0] mat_tangent;
	logic signed [31:0] mat_origin;
	logic signed [31:0] mat_coef;

	point_t expected_points[$];
	row_t   stim_rows[$];
	int     failure_count = 0;
	int     results_seen  = 0;
	int     stall_cycles  = 0;
	int     side_calm[2]  = '{0, 0};

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic logic signed [63:0] sx(input logic [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] a);
		return a[63] ? -a : a;
	endfunction

	function automatic q_t clip_mag(input logic [127:0] m, input logic neg);
		q_t           r;
		logic [127:0] lim;
		logic [127:0] mm;
		lim    = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
		r.clip = m > lim;
		mm     = r.clip ? lim : m;
		r.v    = neg ? -mm[31:0] : mm[31:0];
		return r;
	endfunction

	// truncate the magnitude of the exact product, then clip
	function automatic q_t mul_q(input logic signed [63:0] a, input logic signed [63:0] b);
		logic [127:0] ua;
		logic [127:0] ub;
		ua = {64'b0, mag64(a)};
		ub = {64'b0, mag64(b)};
		if (ua == 0 || ub == 0)
			return '0;
		return clip_mag((ua * ub) >> 16, a[63] ^ b[63]);
	endfunction

	function automatic q_t div_q(input logic signed [31:0] num, input logic [63:0] den);
		q_t          r;
		logic [63:0] n;
		if (num == 0)
			return '0;
		if (den == 0) begin
			r.clip = 1'b1;
			r.v    = num[31] ? NEG_MAX : POS_MAX;
			return r;
		end
		n = mag64(sx(num)) << 16;
		return clip_mag({64'b0, n / den}, num[31]);
	endfunction

	function automatic q_t sat_sum(input logic signed [63:0] v);
		q_t r;
		r.clip = v[63:31] != {33{v[63]}};
		r.v    = r.clip ? (v[63] ? NEG_MAX : POS_MAX) : v[31:0];
		return r;
	endfunction

	function automatic logic [63:0] square_q(input logic signed [31:0] s);
		logic [63:0] md;
		md = mag64(sx(s) - sx(mat_gap));
		return (md * md) >> 16;
	endfunction

	// apply one input word to the material model, return the result word
	function automatic point_t advance_material(input mode_t m, input logic [31:0] s);
		point_t             p;
		q_t                 a;
		q_t                 b;
		logic               clip;
		logic signed [31:0] sv;
		logic               past;
		logic               load;
		logic               unload;
		logic               move;
		clip = 1'b0;
		unique case (m)
			MODE_TRIAL: begin
				sv         = s;
				mat_strain = sv;
				if (!mat_gap[31]) begin
					past   = sv > mat_gap;
					load   = sv > mat_committed;
					unload = sv < mat_committed;
				end else begin
					past   = sv < mat_gap;
					load   = sv < mat_committed;
					unload = sv > mat_committed;
				end
				if (past && load) begin
					a          = mul_q({32'b0, mat_stiff}, sx(sv) - sx(mat_origin));
					mat_stress = a.v;
					clip       = a.clip;
					if (mat_stiff[31]) begin
						mat_tangent = POS_MAX;
						clip        = 1'b1;
					end else begin
						mat_tangent = mat_stiff;
					end
				end else if (past && unload) begin
					a           = mul_q(sx(mat_coef), square_q(sv));
					b           = mul_q(2 * sx(mat_coef), sx(sv) - sx(mat_gap));
					mat_stress  = a.v;
					mat_tangent = b.v;
					clip        = a.clip | b.clip;
				end else begin
					mat_stress  = '0;
					mat_tangent = '0;
				end
			end
			MODE_COMMIT: begin
				sv   = mat_strain;
				past = (mat_gap > 0 && sv > mat_gap) || (mat_gap < 0 && sv < mat_gap);
				// tension side: unloading moves the origin; compression: moving toward zero
				move = (mat_gap > 0) ? (sv < mat_committed) : (sv > mat_committed);
				if (past) begin
					if (move) begin
						a          = div_q(mat_stress, {32'b0, mat_stiff});
						b          = sat_sum(sx(sv) - sx(a.v));
						mat_origin = b.v;
						clip       = a.clip | b.clip;
					end else begin
						a        = div_q(mat_stress, square_q(sv));
						mat_coef = a.v;
						clip     = a.clip;
					end
				end
				mat_committed = sv;
			end
			MODE_REV_COMMIT: begin
				mat_strain = mat_committed;
			end
			default: begin
				mat_committed = '0;
				mat_strain    = '0;
				mat_origin    = mat_gap;
			end
		endcase
		p.stress  = mat_stress;
		p.tangent = mat_tangent;
		p.strain  = mat_strain;
		p.sat     = clip;
		return p;
	endfunction

	// mostly short gaps, a few long ones, and stretches with none
	function automatic int draw_gap(input int side);
		int r;
		if (side_calm[side] > 0) begin
			side_calm[side]--;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			side_calm[side] = $urandom_range(10, 40);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 70);
	endfunction

	// strains cluster around the gap and the last commit, at every scale
	function automatic logic [31:0] pick_strain();
		logic signed [63:0] base;
		logic signed [63:0] off;
		logic signed [63:0] v;
		int                 r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return $urandom();
		if (r < 8)
			return r[0] ? POS_MAX : NEG_MAX;
		base = (r < 55) ? sx(mat_gap) : sx(mat_committed);
		off  = sx($urandom()) >>> (31 - $urandom_range(0, 30));
		v    = base + off;
		if (v[63:31] != {33{v[63]}})
			return v[63] ? NEG_MAX : POS_MAX;
		return v[31:0];
	endfunction

	function automatic row_t word_row(input mode_t m, input logic [31:0] s);
		row_t r;
		r       = '0;
		r.kind  = ROW_WORD;
		r.mode  = m;
		r.value = s;
		return r;
	endfunction

	function automatic row_t checked_row(input mode_t m, input logic [31:0] s,
			input logic [31:0] st, input logic [31:0] tg, input logic [31:0] cs,
			input logic sat);
		row_t r;
		r              = word_row(m, s);
		r.typed        = 1'b1;
		r.want.stress  = st;
		r.want.tangent = tg;
		r.want.strain  = cs;
		r.want.sat     = sat;
		return r;
	endfunction

	function automatic row_t write_row(input reg_idx_t idx, input logic [31:0] data);
		row_t r;
		r       = '0;
		r.kind  = ROW_WRITE;
		r.widx  = idx;
		r.value = data;
		return r;
	endfunction

	task automatic drop_input();
		@(negedge clk);
		item_if.valid <= 1'b0;
	endtask

	// write a register once every pending result has drained
	task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
		drop_input();
		while (expected_points.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_if.valid   <= 1'b1;
		cfg_if.reg_idx <= idx;
		cfg_if.wdata   <= data;
		do
			@(posedge clk);
		while (cfg_if.ready !== 1'b1);
		if (idx == REG_STIFFNESS)
			mat_stiff = data;
		else
			mat_gap = data;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send_word(input mode_t m, input logic [31:0] s, input logic typed,
			input point_t want);
		point_t pred;
		int     n;
		n = draw_gap(SRC_SIDE);
		if (n > 0) begin
			@(negedge clk);
			item_if.valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		item_if.valid  <= 1'b1;
		item_if.mode   <= m;
		item_if.strain <= s;
		do
			@(posedge clk);
		while (item_if.ready !== 1'b1);
		pred = advance_material(m, s);
		expected_points.push_back(typed ? want : pred);
	endtask

	task automatic check_point(input point_t got);
		point_t want;
		if (expected_points.size() == 0) begin
			failure_count++;
			if (failure_count <= MAX_REPORTS)
				$display("result %0d arrived with nothing pending: stress %h tangent %h",
					results_seen, got.stress, got.tangent);
		end else begin
			want = expected_points.pop_front();
			if (got.stress !== want.stress || got.tangent !== want.tangent ||
					got.strain !== want.strain || got.sat !== want.sat) begin
				failure_count++;
				if (failure_count <= MAX_REPORTS)
					$display("result %0d mismatch: expected %h %h %h %b, got %h %h %h %b",
						results_seen, want.stress, want.tangent, want.strain, want.sat,
						got.stress, got.tangent, got.strain, got.sat);
			end
		end
	endtask

	initial begin : result_sink
		point_t got;
		int     n;
		logic   held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			res_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (res_if.valid !== 1'b1);
			got.stress  = res_if.stress;
			got.tangent = res_if.tangent;
			got.strain  = res_if.current_strain;
			got.sat     = res_if.saturated;
			check_point(got);
			results_seen++;
			// hold off once for a long stretch so the block backs up
			if (!held && results_seen == LONG_HOLD_AT) begin
				held = 1'b1;
				n    = LONG_HOLD;
			end else begin
				n = draw_gap(SNK_SIDE);
			end
			if (n > 0) begin
				@(negedge clk);
				res_if.ready <= 1'b0;
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [31:0] stiff;
		logic [31:0] gapv;
		mode_t       m;
		int          r;
		clk            = 1'b0;
		arst_n         = 1'b0;
		item_if.valid  = 1'b0;
		item_if.mode   = MODE_TRIAL;
		item_if.strain = '0;
		cfg_if.valid   = 1'b0;
		cfg_if.reg_idx = REG_STIFFNESS;
		cfg_if.wdata   = '0;
		res_if.ready   = 1'b0;
		mat_stiff      = STIFF_RST;
		mat_gap        = '0;
		mat_committed  = '0;
		mat_strain     = '0;
		mat_stress     = '0;
		mat_tangent    = '0;
		mat_origin     = '0;
		mat_coef       = '0;

		// zero gap at reset: tension rules, commits only move the commit point
		stim_rows.push_back(checked_row(MODE_TRIAL, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0));
		stim_rows.push_back(checked_row(MODE_TRIAL, POS_MAX, POS_MAX, STIFF_RST, POS_MAX,
			1'b0));
		stim_rows.push_back(checked_row(MODE_TRIAL, NEG_MAX, 32'h0, 32'h0, NEG_MAX, 1'b0));
		stim_rows.push_back(checked_row(MODE_COMMIT, 32'h0, 32'h0, 32'h0, NEG_MAX, 1'b0));
		stim_rows.push_back(word_row(MODE_TRIAL, 32'h0001_0000));
		stim_rows.push_back(word_row(MODE_REV_COMMIT, 32'hFFFF_FFFF));
		stim_rows.push_back(word_row(MODE_REV_START, 32'h5A5A_A5A5));
		stim_rows.push_back(word_row(MODE_TRIAL, 32'h0000_8000));
		stim_rows.push_back(word_row(MODE_COMMIT, 32'h0));
		// trial equal to the commit point
		stim_rows.push_back(word_row(MODE_TRIAL, 32'h0000_8000));
		stim_rows.push_back(word_row(MODE_TRIAL, 32'h0000_4000));
		// compression side with stiffness above the signed range
		stim_rows.push_back(write_row(REG_GAP, 32'hFFFF_0000));
		stim_rows.push_back(write_row(REG_STIFFNESS, 32'hFFFF_FFFF));
		stim_rows.push_back(word_row(MODE_REV_START, 32'h0));
		stim_rows.push_back(word_row(MODE_TRIAL, 32'hFFFE_FFF0));
		// square truncates to zero: divide by zero at commit
		stim_rows.push_back(word_row(MODE_COMMIT, 32'h0));
		stim_rows.push_back(word_row(MODE_TRIAL, 32'hFFFE_0000));
		stim_rows.push_back(word_row(MODE_COMMIT, 32'h0));
		// carry a large positive stress over to the compression side
		stim_rows.push_back(write_row(REG_GAP, 32'h0001_0000));
		stim_rows.push_back(word_row(MODE_TRIAL, POS_MAX));
		stim_rows.push_back(word_row(MODE_REV_COMMIT, 32'h0));
		stim_rows.push_back(write_row(REG_GAP, 32'hFFFF_0000));
		stim_rows.push_back(write_row(REG_STIFFNESS, 32'h0000_0001));
		stim_rows.push_back(word_row(MODE_COMMIT, 32'h0));
		stim_rows.push_back(word_row(MODE_TRIAL, 32'hFFFE_8000));
		// origin falls out of range
		stim_rows.push_back(word_row(MODE_COMMIT, 32'h0));
		stim_rows.push_back(word_row(MODE_TRIAL, 32'hFFFD_0000));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (stim_rows[i]) begin
			if (stim_rows[i].kind == ROW_WRITE)
				write_reg(stim_rows[i].widx, stim_rows[i].value);
			else
				send_word(stim_rows[i].mode, stim_rows[i].value, stim_rows[i].typed,
					stim_rows[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			unique case (p)
				0: begin
					stiff = STIFF_RST;
					gapv  = 32'h0001_0000;
				end
				1: begin
					stiff = 32'h0002_0000;
					gapv  = 32'hFFFF_8000;
				end
				2: begin
					stiff = 32'hFFFF_FFFF;
					gapv  = POS_MAX;
				end
				3: begin
					stiff = 32'h0000_0001;
					gapv  = NEG_MAX;
				end
				4: begin
					stiff = STIFF_RST;
					gapv  = 32'h0;
				end
				default: begin
					stiff = $urandom() >> $urandom_range(0, 24);
					if (stiff == 0)
						stiff = 32'h0000_0001;
					gapv = 32'(sx($urandom()) >>> $urandom_range(4, 31));
				end
			endcase
			write_reg(REG_STIFFNESS, stiff);
			write_reg(REG_GAP, gapv);
			// restart so the loading origin picks up the new gap
			send_word(MODE_REV_START, $urandom(), 1'b0, '0);
			repeat (PHASE_WORDS - 1) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					m = MODE_TRIAL;
				else if (r < 85)
					m = MODE_COMMIT;
				else if (r < 93)
					m = MODE_REV_COMMIT;
				else
					m = MODE_REV_START;
				send_word(m, (m == MODE_TRIAL) ? pick_strain() : $urandom(), 1'b0, '0);
			end
		end

		drop_input();
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failure_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
